@@ rtl/blrt_pkg.sv @@
// ----------------------------------------------------------------------------
// blrt_pkg: shared types and constants
// Sizes, command and event codes, sequencer states, chain and cell control, side clamp.
// ----------------------------------------------------------------------------
package blrt_pkg;

  localparam int ENTRIES   = 32;
  localparam int ENTRY_W   = 5;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int SIDE_W    = 13;
  localparam int MAX_SIDE  = 4096;
  localparam int TEXEL_W   = 25;
  localparam int USAGE_W   = 32;
  localparam int CMD_W     = 3;
  localparam int EV_W      = 3;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 48;
  localparam logic [USAGE_W-1:0] BUDGET_RST = 32'd268435456;

  typedef enum logic [CMD_W-1:0] {
    CMD_USE     = 3'd0,
    CMD_QUERY   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_REL_ALL = 3'd3,
    CMD_EOF     = 3'd4
  } cmd_e;

  typedef enum logic [EV_W-1:0] {
    EV_HIT      = 3'd0,
    EV_LOADED   = 3'd1,
    EV_RELEASED = 3'd2,
    EV_NOCHG    = 3'd3,
    EV_EVICTED  = 3'd4,
    EV_DONE     = 3'd5
  } ev_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_LOAD,
    S_MOVE,
    S_REPLY,
    S_FREE,
    S_RALL,
    S_EOF
  } state_e;

  typedef struct packed {
    logic               rm;
    logic               rm_by_pos;
    logic               wr;
    logic [IDX_W-1:0]   rm_pos;
    logic [IDX_W-1:0]   wr_pos;
    logic [ENTRY_W-1:0] key;
    logic [ENTRY_W-1:0] new_id;
    logic [CNT_W-1:0]   cnt;
  } chain_ctl_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    else if (v == '0) r = SIDE_W'(1);
    return r;
  endfunction

endpackage

@@ rtl/blrt_cell.sv @@
// ----------------------------------------------------------------------------
// blrt_cell: one recency slot
// Holds one entry id; takes the id of the next newer slot on a shift.
// ----------------------------------------------------------------------------
module blrt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  blrt_pkg::cell_ctl_t          ctl_i,
  input  logic [blrt_pkg::ENTRY_W-1:0] new_id_i,
  input  logic [blrt_pkg::ENTRY_W-1:0] upper_id_i,
  output logic [blrt_pkg::ENTRY_W-1:0] id_o
);

  logic [blrt_pkg::ENTRY_W-1:0] id_q, id_d;

  always_comb begin
    id_d = id_q;
    if (ctl_i.write) begin
      id_d = new_id_i;
    end else if (ctl_i.shift) begin
      id_d = upper_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= '0;
    end else begin
      id_q <= id_d;
    end
  end

  assign id_o = id_q;

endmodule

@@ rtl/blrt_chain.sv @@
// ----------------------------------------------------------------------------
// blrt_chain: recency order as a row of slots
// Slot 0 is least recent. Removal closes the gap, append writes one slot.
// ----------------------------------------------------------------------------
module blrt_chain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  blrt_pkg::chain_ctl_t         ctl_i,
  output logic [blrt_pkg::ENTRY_W-1:0] ids_o [blrt_pkg::ENTRIES]
);

  logic [blrt_pkg::ENTRIES-1:0] hit;
  logic [blrt_pkg::ENTRIES-1:0] ge;
  blrt_pkg::cell_ctl_t          cctl [blrt_pkg::ENTRIES];
  logic [blrt_pkg::ENTRY_W-1:0] upper [blrt_pkg::ENTRIES];

  always_comb begin
    for (int i = 0; i < blrt_pkg::ENTRIES; i++) begin
      if (ctl_i.rm_by_pos) begin
        hit[i] = (ctl_i.rm_pos == blrt_pkg::IDX_W'(i));
      end else begin
        hit[i] = (ids_o[i] == ctl_i.key) && (blrt_pkg::CNT_W'(i) < ctl_i.cnt);
      end
    end
    ge[0] = hit[0];
    for (int i = 1; i < blrt_pkg::ENTRIES; i++) begin
      ge[i] = ge[i-1] | hit[i];
    end
    for (int i = 0; i < blrt_pkg::ENTRIES; i++) begin
      cctl[i].shift = ctl_i.rm & ge[i];
      cctl[i].write = ctl_i.wr & (ctl_i.wr_pos == blrt_pkg::IDX_W'(i));
      upper[i]      = (i == blrt_pkg::ENTRIES - 1) ? '0 : ids_o[(i + 1) % blrt_pkg::ENTRIES];
    end
  end

  for (genvar g = 0; g < blrt_pkg::ENTRIES; g++) begin : g_cell
    blrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cctl[g]),
      .new_id_i   (ctl_i.new_id),
      .upper_id_i (upper[g]),
      .id_o       (ids_o[g])
    );
  end

endmodule

@@ rtl/budgeted_lru_residency_tracker.sv @@
// ----------------------------------------------------------------------------
// budgeted_lru_residency_tracker: LRU residency with byte budget eviction
// Channel  Dir  Fields (low bit up)
// s_axis   in   tdata: command[2:0] entry[7:3] width[20:8] height[33:21]
// m_axis   out  tdata: result_entry[4:0] event_res[7:5] loaded_count[13:8]
//                      usage_bytes[45:14]; tlast: last
// cfg      in   cfg_wdata_i: memory_budget
// Use/query/release go through dispatch, multiply (loads only) and update.
// Release all walks every entry index; end of frame walks the recency chain
// from the least recent slot.
// Reset clears the residency, order and usage state at once; no clearing pass.
// A stalled output holds the sequencer in its emitting state.
// ----------------------------------------------------------------------------
module budgeted_lru_residency_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [blrt_pkg::IN_W-1:0]     s_axis_tdata_i,  // command, entry, width, height
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [blrt_pkg::OUT_W-1:0]    m_axis_tdata_o,  // entry, event, count, usage
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_we_i,
  input  logic [blrt_pkg::USAGE_W-1:0]  cfg_wdata_i
);

  localparam int EW = blrt_pkg::ENTRY_W;
  localparam int CW = blrt_pkg::CNT_W;
  localparam int IW = blrt_pkg::IDX_W;
  localparam int UW = blrt_pkg::USAGE_W;
  localparam int TW = blrt_pkg::TEXEL_W;
  localparam int SW = blrt_pkg::SIDE_W;
  localparam int N  = blrt_pkg::ENTRIES;

  blrt_pkg::state_e      state_q, state_d;
  logic [blrt_pkg::CMD_W-1:0] cmd_q;
  logic [EW-1:0]         e_q;
  logic [SW-1:0]         w_q, h_q;
  logic [TW-1:0]         texel_q;
  blrt_pkg::ev_e         ev_q, ev_d;
  logic [CW-1:0]         idx_q, pos_q, cnt_q, cnt_d;
  logic [UW-1:0]         usage_q, usage_d, budget_q;
  logic [N-1:0]          res_q, sk_q, used_q;
  logic [TW-1:0]         tex_mem [N];
  logic [EW-1:0]         ids [N];

  logic                  mv_q;
  logic [blrt_pkg::OUT_W-1:0] md_q;
  logic                  ml_q;

  logic                  out_free, valid_e, pos_in;
  logic [EW-1:0]         cur, mru, fe;
  logic [2*SW-1:0]       prod;
  logic [TW+1:0]         fbytes;
  logic [UW:0]           sum;
  logic [UW-1:0]         usage_add, usage_sub;

  logic                  emit, emit_last, do_load, do_free, set_used, clr_used;
  logic                  idx_inc, pos_inc;
  logic [EW-1:0]         emit_ent;
  blrt_pkg::ev_e         emit_ev;
  blrt_pkg::chain_ctl_t  cctl;

  blrt_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .ids_o  (ids)
  );

  assign s_axis_tready_o = (state_q == blrt_pkg::S_IDLE);
  assign out_free  = !mv_q || m_axis_tready_i;
  assign valid_e   = ({1'b0, e_q} < CW'(N));
  assign pos_in    = (pos_q < cnt_q);
  assign cur       = ids[pos_q[IW-1:0]];
  assign mru       = ids[IW'(cnt_q - CW'(1))];
  assign prod      = w_q * h_q;

  always_comb begin
    fe = e_q;
    if (state_q == blrt_pkg::S_RALL) fe = EW'(idx_q);
    else if (state_q == blrt_pkg::S_EOF) fe = cur;
  end

  assign fbytes    = {tex_mem[fe[IW-1:0]], 2'b00};
  assign usage_sub = (UW'(fbytes) >= usage_q) ? '0 : usage_q - UW'(fbytes);
  assign sum       = {1'b0, usage_q} + (UW+1)'({texel_q, 2'b00});
  assign usage_add = sum[UW] ? '1 : sum[UW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    ev_d    = ev_q;
    unique case (state_q)
      blrt_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) state_d = blrt_pkg::S_DISPATCH;
      end
      blrt_pkg::S_DISPATCH: begin
        state_d = blrt_pkg::S_REPLY;
        ev_d    = blrt_pkg::EV_NOCHG;
        if (cmd_q == blrt_pkg::CMD_REL_ALL) begin
          state_d = blrt_pkg::S_RALL;
        end else if (cmd_q == blrt_pkg::CMD_EOF) begin
          state_d = blrt_pkg::S_EOF;
        end else if (valid_e) begin
          priority case (cmd_q)
            blrt_pkg::CMD_USE: begin
              if (!res_q[e_q[IW-1:0]]) begin
                state_d = blrt_pkg::S_MUL;
              end else if (mru == e_q) begin
                ev_d = blrt_pkg::EV_HIT;
              end else begin
                state_d = blrt_pkg::S_MOVE;
              end
            end
            blrt_pkg::CMD_QUERY: begin
              if (!sk_q[e_q[IW-1:0]] && !res_q[e_q[IW-1:0]]) state_d = blrt_pkg::S_MUL;
            end
            blrt_pkg::CMD_RELEASE: begin
              if (res_q[e_q[IW-1:0]]) state_d = blrt_pkg::S_FREE;
            end
            default: state_d = blrt_pkg::S_REPLY;
          endcase
        end
      end
      blrt_pkg::S_MUL: state_d = blrt_pkg::S_LOAD;
      blrt_pkg::S_LOAD, blrt_pkg::S_MOVE, blrt_pkg::S_REPLY, blrt_pkg::S_FREE: begin
        if (out_free) state_d = blrt_pkg::S_IDLE;
      end
      blrt_pkg::S_RALL: begin
        if (idx_q == CW'(N) && out_free) state_d = blrt_pkg::S_IDLE;
      end
      blrt_pkg::S_EOF: begin
        if (!(pos_in && !used_q[cur[IW-1:0]]) && out_free) state_d = blrt_pkg::S_IDLE;
      end
      default: state_d = blrt_pkg::S_IDLE;
    endcase
  end

  // actions
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b1;
    emit_ent  = e_q;
    emit_ev   = ev_q;
    do_load   = 1'b0;
    do_free   = 1'b0;
    set_used  = 1'b0;
    clr_used  = 1'b0;
    idx_inc   = 1'b0;
    pos_inc   = 1'b0;
    cctl      = '0;
    cctl.cnt  = cnt_q;
    cctl.key  = fe;
    cctl.new_id = e_q;
    unique case (state_q)
      blrt_pkg::S_DISPATCH: begin
        set_used = (cmd_q == blrt_pkg::CMD_USE) && valid_e;
      end
      blrt_pkg::S_LOAD: begin
        if (out_free) begin
          do_load     = 1'b1;
          emit        = 1'b1;
          emit_ev     = blrt_pkg::EV_LOADED;
          cctl.wr     = 1'b1;
          cctl.wr_pos = IW'(cnt_q);
        end
      end
      blrt_pkg::S_MOVE: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_ev     = blrt_pkg::EV_HIT;
          cctl.rm     = 1'b1;
          cctl.wr     = 1'b1;
          cctl.wr_pos = IW'(cnt_q - CW'(1));
        end
      end
      blrt_pkg::S_REPLY: begin
        emit = out_free;
      end
      blrt_pkg::S_FREE: begin
        if (out_free) begin
          do_free = 1'b1;
          emit    = 1'b1;
          emit_ev = blrt_pkg::EV_RELEASED;
          cctl.rm = 1'b1;
        end
      end
      blrt_pkg::S_RALL: begin
        if (idx_q == CW'(N)) begin
          emit     = out_free;
          emit_ent = '0;
          emit_ev  = blrt_pkg::EV_DONE;
        end else if (res_q[idx_q[IW-1:0]]) begin
          if (out_free) begin
            do_free   = 1'b1;
            emit      = 1'b1;
            emit_last = 1'b0;
            emit_ent  = fe;
            emit_ev   = blrt_pkg::EV_RELEASED;
            cctl.rm   = 1'b1;
            idx_inc   = 1'b1;
          end
        end else begin
          idx_inc = 1'b1;
        end
      end
      blrt_pkg::S_EOF: begin
        if (pos_in && !used_q[cur[IW-1:0]]) begin
          if (usage_q > budget_q) begin
            if (out_free) begin
              do_free        = 1'b1;
              emit           = 1'b1;
              emit_last      = 1'b0;
              emit_ent       = cur;
              emit_ev        = blrt_pkg::EV_EVICTED;
              cctl.rm        = 1'b1;
              cctl.rm_by_pos = 1'b1;
              cctl.rm_pos    = pos_q[IW-1:0];
            end
          end else begin
            pos_inc = 1'b1;
          end
        end else if (out_free) begin
          clr_used = 1'b1;
          emit     = 1'b1;
          emit_ent = '0;
          emit_ev  = blrt_pkg::EV_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    usage_d = usage_q;
    if (do_load) begin
      cnt_d   = cnt_q + CW'(1);
      usage_d = usage_add;
    end else if (do_free) begin
      cnt_d   = cnt_q - CW'(1);
      usage_d = usage_sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= blrt_pkg::S_IDLE;
      ev_q     <= blrt_pkg::EV_NOCHG;
      idx_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      usage_q  <= '0;
      budget_q <= blrt_pkg::BUDGET_RST;
      res_q    <= '0;
      sk_q     <= '0;
      used_q   <= '0;
      mv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
      cnt_q   <= cnt_d;
      usage_q <= usage_d;
      if (cfg_we_i) budget_q <= cfg_wdata_i;
      if (state_q == blrt_pkg::S_DISPATCH) begin
        idx_q <= '0;
        pos_q <= '0;
      end else begin
        if (idx_inc) idx_q <= idx_q + CW'(1);
        if (pos_inc) pos_q <= pos_q + CW'(1);
      end
      if (set_used) used_q[e_q[IW-1:0]] <= 1'b1;
      if (clr_used) used_q <= used_q & ~res_q;
      if (do_load) begin
        res_q[e_q[IW-1:0]] <= 1'b1;
        sk_q[e_q[IW-1:0]]  <= 1'b1;
      end
      if (do_free) res_q[fe[IW-1:0]] <= 1'b0;
      if (emit) mv_q <= 1'b1;
      else if (m_axis_tready_i) mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q <= s_axis_tdata_i[2:0];
      e_q   <= s_axis_tdata_i[7:3];
      w_q   <= blrt_pkg::sat_side(s_axis_tdata_i[20:8]);
      h_q   <= blrt_pkg::sat_side(s_axis_tdata_i[33:21]);
    end
    if (state_q == blrt_pkg::S_MUL) texel_q <= prod[TW-1:0];
    if (do_load) tex_mem[e_q[IW-1:0]] <= texel_q;
    if (emit) begin
      md_q <= {2'b00, usage_d, cnt_d, emit_ev, emit_ent};
      ml_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = md_q;
  assign m_axis_tlast_o  = ml_q;

endmodule

@@ tb/tb_budgeted_lru_residency_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_budgeted_lru_residency_tracker: stream-level check of the LRU tracker
// Drives command items through the input stream, predicts every result item
// with a behavioral recency list, byte usage and budget, and compares each
// output item field by field. Random stalls on both sides, budget changes
// between phases.
// ----------------------------------------------------------------------------
module tb_budgeted_lru_residency_tracker;

  localparam logic [5:0] NIL = 6'd63;

  typedef struct packed {
    logic [4:0]  ent;
    logic [2:0]  ev;
    logic [5:0]  cnt;
    logic [31:0] usage;
    logic        last;
  } res_t;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid_i = 0, m_axis_tready_i = 0, cfg_we_i = 0;
  logic [blrt_pkg::IN_W-1:0] s_axis_tdata_i = '0;
  logic [blrt_pkg::USAGE_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tready_o, m_axis_tvalid_o, m_axis_tlast_o;
  logic [blrt_pkg::OUT_W-1:0] m_axis_tdata_o;

  budgeted_lru_residency_tracker dut (.*);

  // predictor state
  logic        res_q [blrt_pkg::ENTRIES];
  logic        known_q [blrt_pkg::ENTRIES];
  logic        used_q [blrt_pkg::ENTRIES];
  logic [24:0] texels_q [blrt_pkg::ENTRIES];
  logic [5:0]  older_q [blrt_pkg::ENTRIES];
  logic [5:0]  newer_q [blrt_pkg::ENTRIES];
  logic [5:0]  mru_q, lru_q, total_q;
  logic [31:0] usage_q, budget_q;

  res_t expected_results[$];
  logic [blrt_pkg::IN_W-1:0] pending_items[$];
  int errors = 0, n_items = 0, n_results = 0, n_evicts = 0;
  int send_idle = 32, recv_idle = 78;
  int hold_left = 0;

  initial forever #6 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void emit_result(input logic [4:0] e, input blrt_pkg::ev_e ev,
                                      input bit l);
    res_t r;
    r.ent = e; r.ev = ev; r.cnt = total_q; r.usage = usage_q; r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void unlink(input int e);
    logic [5:0] o, n;
    o = older_q[e]; n = newer_q[e];
    if (o < blrt_pkg::ENTRIES) newer_q[o] = n;
    if (n < blrt_pkg::ENTRIES) older_q[n] = o;
    if (lru_q == e) lru_q = n;
    if (mru_q == e) mru_q = o;
    older_q[e] = NIL; newer_q[e] = NIL;
  endfunction

  function automatic void to_front(input int e);
    if (mru_q < blrt_pkg::ENTRIES) newer_q[mru_q] = 6'(e);
    older_q[e] = mru_q; newer_q[e] = NIL; mru_q = 6'(e);
    if (lru_q == NIL) lru_q = 6'(e);
  endfunction

  function automatic logic [12:0] clamp_side(input logic [12:0] v);
    if (v > 13'd4096) return 13'd4096;
    if (v == 0) return 13'd1;
    return v;
  endfunction

  function automatic void load(input int e, input logic [12:0] w, input logic [12:0] h);
    logic [24:0] t;
    logic [33:0] sum;
    t = 25'(clamp_side(w)) * 25'(clamp_side(h));
    sum = 34'(usage_q) + 34'(t) * 4;
    texels_q[e] = t; known_q[e] = 1; res_q[e] = 1; total_q++;
    usage_q = sum > 34'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
    to_front(e);
  endfunction

  function automatic bit free(input int e);
    logic [33:0] b;
    if (!res_q[e]) return 0;
    res_q[e] = 0;
    if (total_q != 0) total_q--;
    b = 34'(texels_q[e]) * 4;
    usage_q = b >= 34'(usage_q) ? 32'd0 : usage_q - b[31:0];
    unlink(e);
    return 1;
  endfunction

  function automatic void predict_item(input logic [blrt_pkg::IN_W-1:0] d);
    logic [2:0] c;
    logic [4:0] e;
    logic [5:0] cur, victim;
    int steps;
    c = d[2:0]; e = d[7:3];
    if (c == blrt_pkg::CMD_REL_ALL) begin
      for (int i = 0; i < blrt_pkg::ENTRIES; i++)
        if (free(i)) emit_result(5'(i), blrt_pkg::EV_RELEASED, 0);
      emit_result(0, blrt_pkg::EV_DONE, 1);
    end else if (c == blrt_pkg::CMD_EOF) begin
      cur = lru_q; steps = 0;
      while (cur < blrt_pkg::ENTRIES && steps < blrt_pkg::ENTRIES && !used_q[cur]) begin
        victim = cur; cur = newer_q[cur];
        if (usage_q > budget_q && free(victim))
          emit_result(victim[4:0], blrt_pkg::EV_EVICTED, 0);
        steps++;
      end
      steps = 0;
      while (cur < blrt_pkg::ENTRIES && steps < blrt_pkg::ENTRIES) begin
        used_q[cur] = 0; cur = newer_q[cur]; steps++;
      end
      emit_result(0, blrt_pkg::EV_DONE, 1);
    end else if (c > blrt_pkg::CMD_EOF) begin
      emit_result(e, blrt_pkg::EV_NOCHG, 1);
    end else if (c == blrt_pkg::CMD_USE) begin
      if (!res_q[e]) begin
        load(e, d[20:8], d[33:21]);
        used_q[e] = 1;
        emit_result(e, blrt_pkg::EV_LOADED, 1);
      end else begin
        used_q[e] = 1;
        if (mru_q != e) begin unlink(e); to_front(e); end
        emit_result(e, blrt_pkg::EV_HIT, 1);
      end
    end else if (c == blrt_pkg::CMD_QUERY) begin
      if (!known_q[e] && !res_q[e]) begin
        load(e, d[20:8], d[33:21]);
        emit_result(e, blrt_pkg::EV_LOADED, 1);
      end else emit_result(e, blrt_pkg::EV_NOCHG, 1);
    end else begin
      emit_result(e, free(e) ? blrt_pkg::EV_RELEASED : blrt_pkg::EV_NOCHG, 1);
    end
  endfunction

  function automatic logic [blrt_pkg::IN_W-1:0] pack_item(input logic [2:0] c,
                                                          input logic [4:0] e,
                                                          input logic [12:0] w,
                                                          input logic [12:0] h);
    return {6'd0, h, w, e, c};
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_item(s_axis_tdata_i);
        n_items++;
      end
      if ((!s_axis_tvalid_i || s_axis_tready_o) && pending_items.size() > 0 &&
          $urandom_range(99) >= send_idle) begin
        s_axis_tvalid_i <= 1;
        s_axis_tdata_i <= pending_items.pop_front();
      end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
        s_axis_tvalid_i <= 0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[4:0], m_axis_tdata_o[7:5], m_axis_tdata_o[13:8],
               m_axis_tdata_o[45:14], m_axis_tlast_o};
        n_results++;
        if (got.ev == blrt_pkg::EV_EVICTED) n_evicts++;
        if (expected_results.size() == 0) report("result with no expectation");
        else begin
          exp_r = expected_results.pop_front();
          if (got.ent !== exp_r.ent) report($sformatf("entry %0d exp %0d", got.ent, exp_r.ent));
          if (got.ev !== exp_r.ev) report($sformatf("event %0d exp %0d", got.ev, exp_r.ev));
          if (got.cnt !== exp_r.cnt) report($sformatf("count %0d exp %0d", got.cnt, exp_r.cnt));
          if (got.usage !== exp_r.usage)
            report($sformatf("usage %0d exp %0d", got.usage, exp_r.usage));
          if (got.last !== exp_r.last) report($sformatf("last %0b exp %0b", got.last, exp_r.last));
        end
      end
      m_axis_tready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic wait_drain();
    while (pending_items.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (blrt_pkg::ENTRIES + 10) @(posedge clk_i);
  endtask

  task automatic set_budget(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    budget_q = v;
  endtask

  task automatic add_random(input int n);
    int r;
    logic [2:0] c;
    logic [12:0] w, h;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) c = blrt_pkg::CMD_USE;
      else if (r < 60) c = blrt_pkg::CMD_QUERY;
      else if (r < 75) c = blrt_pkg::CMD_RELEASE;
      else if (r < 78) c = blrt_pkg::CMD_REL_ALL;
      else if (r < 95) c = blrt_pkg::CMD_EOF;
      else c = 3'($urandom_range(7, 5));
      r = $urandom_range(9);
      w = r == 0 ? 13'($urandom) : 13'($urandom_range(4096, 1));
      h = r == 1 ? 13'($urandom) : 13'($urandom_range(r < 5 ? 64 : 4096, 1));
      pending_items.push_back(pack_item(c, 5'($urandom), w, h));
    end
  endtask

  initial begin
    for (int i = 0; i < blrt_pkg::ENTRIES; i++) begin
      res_q[i] = 0; known_q[i] = 0; used_q[i] = 0; texels_q[i] = 0;
      older_q[i] = NIL; newer_q[i] = NIL;
    end
    mru_q = NIL; lru_q = NIL; total_q = 0; usage_q = 0; budget_q = blrt_pkg::BUDGET_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    // directed
    pending_items.push_back(pack_item(blrt_pkg::CMD_QUERY, 5'd3, 13'd0, 13'h1FFF));
    pending_items.push_back(pack_item(blrt_pkg::CMD_QUERY, 5'd3, 13'd5, 13'd5));
    pending_items.push_back(pack_item(blrt_pkg::CMD_USE, 5'd0, 13'd4096, 13'd4096));
    pending_items.push_back(pack_item(blrt_pkg::CMD_USE, 5'd31, 13'h1FFF, 13'h1FFF));
    pending_items.push_back(pack_item(blrt_pkg::CMD_USE, 5'd0, 13'd1, 13'd1));
    pending_items.push_back(pack_item(blrt_pkg::CMD_RELEASE, 5'd31, 13'd1, 13'd1));
    pending_items.push_back(pack_item(blrt_pkg::CMD_RELEASE, 5'd31, 13'd1, 13'd1));
    pending_items.push_back(pack_item(blrt_pkg::CMD_QUERY, 5'd31, 13'd2, 13'd2));
    pending_items.push_back(pack_item(3'd5, 5'd7, 13'd1, 13'd1));
    pending_items.push_back(pack_item(3'd7, 5'd9, 13'd1, 13'd1));
    pending_items.push_back(pack_item(blrt_pkg::CMD_EOF, 5'd0, 13'd0, 13'd0));
    pending_items.push_back(pack_item(blrt_pkg::CMD_EOF, 5'd0, 13'd0, 13'd0));
    pending_items.push_back(pack_item(blrt_pkg::CMD_REL_ALL, 5'd0, 13'd0, 13'd0));
    pending_items.push_back(pack_item(blrt_pkg::CMD_REL_ALL, 5'd0, 13'd0, 13'd0));
    wait_drain();
    set_budget(32'd0);
    for (int i = 0; i < 16; i++)
      pending_items.push_back(pack_item(blrt_pkg::CMD_USE, 5'(i), 13'd4096, 13'd4096));
    pending_items.push_back(pack_item(blrt_pkg::CMD_EOF, 5'd0, 13'd0, 13'd0));
    pending_items.push_back(pack_item(blrt_pkg::CMD_EOF, 5'd0, 13'd0, 13'd0));
    wait_drain();
    // long receiver hold-off while items are queued for the sender
    hold_left = 400;
    add_random(40);
    wait (hold_left == 0);
    wait_drain();
    set_budget(32'd20000000);
    add_random(60);
    wait_drain();
    send_idle = 78; recv_idle = 32;
    set_budget(32'hFFFF_FFFF);
    add_random(40);
    wait_drain();
    send_idle = 0; recv_idle = 0;
    set_budget(32'd1000000);
    add_random(60);
    wait_drain();
    $display("covered %0d items, %0d results, %0d evictions, budgets 0 to max",
             n_items, n_results, n_evicts);
    if (errors == 0 && expected_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end
endmodule

@@ budgeted_lru_residency_tracker.f @@
rtl/blrt_pkg.sv
rtl/blrt_cell.sv
rtl/blrt_chain.sv
rtl/budgeted_lru_residency_tracker.sv
tb/tb_budgeted_lru_residency_tracker.sv
